// ===== hdl/cct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the character class tokenizer.
// Used by cct_front, cct_cmd_fifo, cct_back and char_class_tokenizer_core.
package cct_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 64;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int MAP_WORDS         = 4;
    localparam int CMD_DEPTH         = 4;
    localparam int CMD_PTR_W         = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W         = $clog2(CMD_DEPTH + 1);

    // Tab, LF, CR and space in the lowest separator word
    localparam logic [CFG_DATA_W-1:0] SEP_MAP_0_RESET = 64'h0000_0001_0000_2600;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SEP_0    = 3'd0,
        REG_SEP_1    = 3'd1,
        REG_SEP_2    = 3'd2,
        REG_SEP_3    = 3'd3,
        REG_SINGLE_0 = 3'd4,
        REG_SINGLE_1 = 3'd5,
        REG_SINGLE_2 = 3'd6,
        REG_SINGLE_3 = 3'd7
    } cfg_reg_t;

    // One classified input: up to two results, in the order pre_end, char, post_end
    typedef struct packed {
        logic [7:0] ch;
        logic       pre_end;
        logic       has_char;
        logic       start;
        logic       single;
        logic       post_end;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [7:0] token_char;
        logic       char_valid;
        logic       token_start;
        logic       token_end;
        logic       is_single;
        logic       last_result;
    } result_t;

endpackage

// ===== hdl/cct_front.sv =====
`timescale 1ns / 1ps
// Front end: class maps, byte classification and word state.
// Turns each accepted byte into at most one command; depends on cct_pkg.
module cct_front #(
    parameter int MAX_TOKEN_LEN = cct_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cct_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cct_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            end_of_string,
    input  logic                            q_full,
    output logic                            q_push,
    output cct_pkg::cmd_t                   q_cmd
);
    import cct_pkg::*;

    localparam int LEN_W = (MAX_TOKEN_LEN > 2) ? $clog2(MAX_TOKEN_LEN) : 1;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_LEN - 1);

    logic [MAP_WORDS-1:0][CFG_DATA_W-1:0] sep_map_reg;
    logic [MAP_WORDS-1:0][CFG_DATA_W-1:0] single_map_reg;
    logic                                 in_word_reg;
    logic                                 in_word_next;
    logic [LEN_W-1:0]                     word_len_reg;
    logic [LEN_W-1:0]                     word_len_next;

    logic             accept;
    logic             is_zero;
    logic             is_sep;
    logic             is_single;
    logic             is_word;
    logic             first;
    logic [LEN_W-1:0] len_eff;
    logic             emit_word;
    cmd_t             cmd;

    // Write class map words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_map_reg       <= {{((MAP_WORDS - 1) * CFG_DATA_W){1'b0}}, SEP_MAP_0_RESET};
            single_map_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SEP_0:    sep_map_reg[0]    <= cfg_data;
                REG_SEP_1:    sep_map_reg[1]    <= cfg_data;
                REG_SEP_2:    sep_map_reg[2]    <= cfg_data;
                REG_SEP_3:    sep_map_reg[3]    <= cfg_data;
                REG_SINGLE_0: single_map_reg[0] <= cfg_data;
                REG_SINGLE_1: single_map_reg[1] <= cfg_data;
                REG_SINGLE_2: single_map_reg[2] <= cfg_data;
                REG_SINGLE_3: single_map_reg[3] <= cfg_data;
            endcase
        end
    end

    // Classify the byte: separator wins over single, zero is neither
    always_comb
    begin
        is_zero   = (in_byte == 8'd0);
        is_sep    = !is_zero && sep_map_reg[in_byte[7:6]][in_byte[5:0]];
        is_single = !is_zero && !is_sep && single_map_reg[in_byte[7:6]][in_byte[5:0]];
        is_word   = !is_zero && !is_sep && !is_single;
        first     = !in_word_reg;
        len_eff   = first ? '0 : word_len_reg;
        emit_word = is_word && (len_eff < LEN_LIMIT);
    end

    // Build the command for this byte
    always_comb
    begin
        cmd.ch       = in_byte;
        cmd.pre_end  = !is_word && in_word_reg;
        cmd.has_char = is_single || emit_word;
        cmd.start    = is_single || first;
        cmd.single   = is_single;
        cmd.post_end = end_of_string && is_word;
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_cmd    = cmd;
    assign q_push   = accept && (cmd.pre_end || cmd.has_char || cmd.post_end);

    // Advance word state; end of string or a non-word byte closes the word
    always_comb
    begin
        in_word_next  = in_word_reg;
        word_len_next = word_len_reg;
        if (accept)
        begin
            if (end_of_string || !is_word)
            begin
                in_word_next  = 1'b0;
                word_len_next = '0;
            end
            else
            begin
                in_word_next  = 1'b1;
                word_len_next = emit_word ? len_eff + LEN_W'(1) : len_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg  <= 1'b0;
            word_len_reg <= '0;
        end
        else
        begin
            in_word_reg  <= in_word_next;
            word_len_reg <= word_len_next;
        end
    end

endmodule

// ===== hdl/cct_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on cct_pkg for the command type and depth.
module cct_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cct_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output cct_pkg::cmd_t head_cmd
);
    import cct_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + CMD_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + CMD_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CMD_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/cct_back.sv =====
`timescale 1ns / 1ps
// Back end: expands each queued command into one or two result transfers.
// Holds the output register; depends on cct_pkg.
module cct_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  cct_pkg::cmd_t    head_cmd,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output cct_pkg::result_t out_result
);
    import cct_pkg::*;

    logic    phase_reg;
    logic    phase_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;
    result_t out_result_next;

    logic    load;
    logic    two_results;
    logic    last;
    result_t end_res;
    result_t char_res;
    result_t sel_res;

    // Form the candidate results of the head command
    always_comb
    begin
        end_res             = '0;
        end_res.token_end   = 1'b1;
        char_res.token_char  = head_cmd.ch;
        char_res.char_valid  = 1'b1;
        char_res.token_start = head_cmd.start;
        char_res.token_end   = head_cmd.single;
        char_res.is_single   = head_cmd.single;
        char_res.last_result = 1'b0;

        two_results = head_cmd.has_char && (head_cmd.pre_end || head_cmd.post_end);
        last        = phase_reg || !two_results;

        if (phase_reg)
        begin
            sel_res = head_cmd.pre_end ? char_res : end_res;
        end
        else
        begin
            sel_res = (head_cmd.has_char && !head_cmd.pre_end) ? char_res : end_res;
        end
        sel_res.last_result = last;
    end

    // Load the output register when it is empty or being drained
    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && last;

    always_comb
    begin
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (load)
        begin
            phase_next      = !last;
            out_valid_next  = 1'b1;
            out_result_next = sel_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// ===== hdl/char_class_tokenizer_core.sv =====
`timescale 1ns / 1ps
// Top level of the character class tokenizer: front end, command queue, back end.
// Depends on cct_pkg, cct_front, cct_cmd_fifo and cct_back.
//
//  Channel  Dir  Signals                          Transfer
//  s_*      in   s_tvalid s_tready s_tdata s_tlast  one byte, tlast = end of string
//  m_*      out  m_tvalid m_tready m_tdata m_tuser  one result, tlast = last of byte
//                m_tlast
//  cfg_*    in   cfg_we cfg_addr cfg_data           one class map word per write
//
// One byte is taken per cycle while the queue has room. A result passes through the
// command queue and the output register; a byte with two results holds the output
// for two transfers, and the four-entry command queue soaks these up. s_tready drops
// only when the queue is full, m_tready low stalls the back end alone. Reset restores
// the class maps (tab, LF, CR, space as separators) and closes any open word.
module char_class_tokenizer_core #(
    parameter int MAX_TOKEN_LEN = cct_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] in_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] token_char
    output logic [3:0]                     m_tuser,   // [0] char_valid [1] token_start
                                                      // [2] token_end [3] is_single
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [cct_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cct_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cct_pkg::*;

    logic    q_full;
    logic    q_push;
    cmd_t    q_cmd;
    logic    q_pop;
    logic    head_valid;
    cmd_t    head_cmd;
    result_t out_result;

    cct_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .end_of_string (s_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    cct_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    cct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // Pack the result onto the stream
    assign m_tdata = out_result.token_char;
    assign m_tuser = {out_result.is_single, out_result.token_end,
                      out_result.token_start, out_result.char_valid};
    assign m_tlast = out_result.last_result;

endmodule
